@@ rtl/tts_pkg.sv @@
// shared constants and types for the tick task scheduler
`default_nettype none
package tts_pkg;
    localparam int MAX_TASKS      = 8;
    localparam int TICK_WIDTH     = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int ID_WIDTH       = 8;
    localparam int SLOT_W         = $clog2(MAX_TASKS);
    localparam int CNT_W          = $clog2(MAX_TASKS + 1);
    localparam int ENTRY_W        = ID_WIDTH + 2 * TICK_WIDTH + PRIORITY_WIDTH;
    localparam int RESULT_CAP     = 8;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_SORT   = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    typedef struct packed {
        logic [ID_WIDTH-1:0]       id;
        logic [TICK_WIDTH-1:0]     period;
        logic [PRIORITY_WIDTH-1:0] prio;
        logic [TICK_WIDTH-1:0]     remain;
    } entry_t;
endpackage
`default_nettype wire

@@ rtl/tts_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/tick_task_scheduler.sv @@
// tick task scheduler top level: task table in ram, sequencer, result register
// add writes the new entry straight from idle; tick and remove visit the used slots in order
// sort holds entry i, then for each later slot j reads j, compares and on a swap writes both slots
// one item at a time: the table ram (one read, one write port) sets the pace,
// every slot visit reads the entry, then updates or writes it back; output stalls add cycles
// rst_n clears control and the task count; table contents stay unknown
`default_nettype none
module tick_task_scheduler
    import tts_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                operation,
    input  wire logic [ID_WIDTH-1:0]       new_task_id,
    input  wire logic [15:0]               new_period,
    input  wire logic [PRIORITY_WIDTH-1:0] new_priority,
    input  wire logic [15:0]               new_initial_remain,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           fired,
    output logic [7:0]                     fired_task_id,
    output logic [2:0]                     fired_slot,
    output logic                           accepted,
    output logic [3:0]                     task_count,
    output logic                           last
);
    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;  // issue read of slot i
    localparam logic [2:0] S_TICK  = 3'd2;  // entry i ready, update it
    localparam logic [2:0] S_SHIFT = 3'd3;  // entry i ready, write to i-1
    localparam logic [2:0] S_SRDJ  = 3'd4;  // entry i ready, read j
    localparam logic [2:0] S_SCMP  = 3'd5;  // entry j ready, compare
    localparam logic [2:0] S_SWB   = 3'd6;  // write back the old a into j
    localparam logic [2:0] S_DONE  = 3'd7;  // emit final beat

    logic [2:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [3:0]       nfire_reg, nfire_next;
    entry_t           a_reg, a_next;       // held entry at slot i in sort
    logic             any_reg, any_next;   // a firing is parked for this tick; in remove, marks success

    // most recent firing of a tick, parked until it is known whether it is last
    logic [ID_WIDTH-1:0] pk_id_reg, pk_id_next;
    logic [2:0]          pk_slot_reg, pk_slot_next;

    // output register
    logic             ov_reg, ov_next;
    logic             of_reg, of_next, oa_reg, oa_next, ol_reg, ol_next;
    logic [7:0]       oid_reg, oid_next;
    logic [2:0]       oslot_reg, oslot_next;
    logic [3:0]       ocnt_reg, ocnt_next;

    // table ram
    logic              we;
    logic [SLOT_W-1:0] waddr, raddr;
    entry_t            wdata, rdata;

    tts_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic              out_free;
    logic              take;
    logic [TICK_WIDTH-1:0] dec;
    logic              fire;
    logic              need_out;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign take     = in_valid && !in_stall;
    assign dec      = rdata.remain - 1'b1;
    assign fire     = (dec == '0) && (nfire_reg < 4'(RESULT_CAP));
    // a new firing pushes the parked one out as a non-last beat
    assign need_out = fire && any_reg;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        nfire_next   = nfire_reg;
        a_next       = a_reg;
        any_next     = any_reg;
        pk_id_next   = pk_id_reg;
        pk_slot_next = pk_slot_reg;
        ov_next      = ov_reg && out_stall;
        of_next      = of_reg;
        oa_next      = oa_reg;
        ol_next      = ol_reg;
        oid_next     = oid_reg;
        oslot_next   = oslot_reg;
        ocnt_next    = ocnt_reg;
        we           = 1'b0;
        waddr        = i_reg[SLOT_W-1:0];
        wdata        = rdata;
        raddr        = i_reg[SLOT_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    op_next    = operation;
                    i_next     = '0;
                    nfire_next = '0;
                    any_next   = 1'b0;
                    unique case (operation)
                        OP_ADD:
                        begin
                            if (count_reg < CNT_W'(MAX_TASKS))
                            begin
                                we          = 1'b1;
                                waddr       = count_reg[SLOT_W-1:0];
                                wdata.id    = new_task_id;
                                wdata.period = new_period[TICK_WIDTH-1:0];
                                wdata.prio  = new_priority;
                                wdata.remain = new_initial_remain[TICK_WIDTH-1:0];
                                count_next  = count_reg + 1'b1;
                            end
                            ov_next    = 1'b1;
                            of_next    = 1'b0;
                            oid_next   = '0;
                            oslot_next = '0;
                            oa_next    = (count_reg < CNT_W'(MAX_TASKS));
                            ocnt_next  = 4'(count_next);
                            ol_next    = 1'b1;
                        end
                        OP_TICK:
                        begin
                            state_next = (count_reg == '0) ? S_DONE : S_RD;
                        end
                        OP_SORT:
                        begin
                            state_next = (count_reg < CNT_W'(2)) ? S_DONE : S_RD;
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                i_next     = CNT_W'(1);
                                state_next = (count_reg == CNT_W'(1)) ? S_DONE : S_RD;
                                any_next   = 1'b1; // marks success
                                count_next = count_reg - 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_RD:
            begin
                raddr = i_reg[SLOT_W-1:0];
                unique case (op_reg)
                    OP_TICK:   state_next = S_TICK;
                    OP_REMOVE: state_next = S_SHIFT;
                    default:   state_next = S_SRDJ;
                endcase
                if (op_reg == OP_SORT)
                begin
                    j_next = i_reg + 1'b1;
                end
            end
            S_TICK:
            begin
                // stall here while the parked beat cannot move to the output
                if (!need_out || out_free)
                begin
                    we           = 1'b1;
                    waddr        = i_reg[SLOT_W-1:0];
                    wdata.remain = (dec == '0) ? rdata.period : dec;
                    if (fire)
                    begin
                        if (any_reg)
                        begin
                            ov_next    = 1'b1;
                            of_next    = 1'b1;
                            oid_next   = pk_id_reg;
                            oslot_next = pk_slot_reg;
                            oa_next    = 1'b0;
                            ocnt_next  = 4'(count_reg);
                            ol_next    = 1'b0;
                        end
                        pk_id_next   = rdata.id;
                        pk_slot_next = 3'(i_reg);
                        nfire_next   = nfire_reg + 1'b1;
                        any_next     = 1'b1;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 == count_reg) ? S_DONE : S_RD;
                end
                else
                begin
                    raddr = i_reg[SLOT_W-1:0]; // keep the entry on the port
                end
            end
            S_SHIFT:
            begin
                we         = 1'b1;
                waddr      = SLOT_W'(i_reg - 1'b1);
                wdata      = rdata;
                i_next     = i_reg + 1'b1;
                state_next = (i_reg == count_reg) ? S_DONE : S_RD;
            end
            S_SRDJ:
            begin
                a_next     = rdata;
                raddr      = j_reg[SLOT_W-1:0];
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                // keep entry j on the read port for the write-back cycle
                raddr = j_reg[SLOT_W-1:0];
                if (a_reg.prio > rdata.prio)
                begin
                    we         = 1'b1;
                    waddr      = i_reg[SLOT_W-1:0];
                    wdata      = rdata;
                    state_next = S_SWB;
                end
                else
                begin
                    state_next = S_SWB;
                end
            end
            S_SWB:
            begin
                // on a swap the held entry goes to j; the new slot-i value is
                // what was read from j, kept as the held entry
                if (a_reg.prio > rdata.prio)
                begin
                    we     = 1'b1;
                    waddr  = j_reg[SLOT_W-1:0];
                    wdata  = a_reg;
                    a_next = rdata;
                end
                if (j_reg + 1'b1 < count_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    raddr      = SLOT_W'(j_reg + 1'b1);
                    state_next = S_SCMP;
                end
                else if (i_reg + CNT_W'(2) < count_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (op_reg == OP_TICK && any_reg)
                    begin
                        // the parked firing is the last beat of the tick
                        ov_next    = 1'b1;
                        of_next    = 1'b1;
                        oid_next   = pk_id_reg;
                        oslot_next = pk_slot_reg;
                        oa_next    = 1'b0;
                        ocnt_next  = 4'(count_reg);
                        ol_next    = 1'b1;
                    end
                    else
                    begin
                        ov_next    = 1'b1;
                        of_next    = 1'b0;
                        oid_next   = '0;
                        oslot_next = '0;
                        oa_next    = (op_reg == OP_REMOVE) && any_reg;
                        ocnt_next  = 4'(count_reg);
                        ol_next    = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        nfire_reg   <= nfire_next;
        a_reg       <= a_next;
        any_reg     <= any_next;
        pk_id_reg   <= pk_id_next;
        pk_slot_reg <= pk_slot_next;
        of_reg      <= of_next;
        oa_reg      <= oa_next;
        ol_reg      <= ol_next;
        oid_reg     <= oid_next;
        oslot_reg   <= oslot_next;
        ocnt_reg    <= ocnt_next;
    end

    assign out_valid     = ov_reg;
    assign fired         = of_reg;
    assign fired_task_id = oid_reg;
    assign fired_slot    = oslot_reg;
    assign accepted      = oa_reg;
    assign task_count    = ocnt_reg;
    assign last          = ol_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fired) |-> last)
        else $error("non-fire beat without last");
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the tick task scheduler
`timescale 1ns / 100ps
`default_nettype none

class sched_scoreboard;
    typedef struct {
        logic       fired;
        logic [7:0] id;
        logic [2:0] slot;
        logic       acc;
        logic [3:0] cnt;
        logic       last;
    } beat_t;

    logic [7:0]  tid [8];
    logic [15:0] per [8];
    logic [7:0]  pri [8];
    logic [15:0] rem [8];
    int          count;
    beat_t       pending [$];
    int          errors;

    function new();
        count  = 0;
        errors = 0;
    endfunction

    function void push(logic f, logic [7:0] id, logic [2:0] s, logic a, logic l);
        beat_t b;
        b.fired = f; b.id = id; b.slot = s; b.acc = a; b.cnt = count[3:0]; b.last = l;
        pending.push_back(b);
    endfunction

    // predict the beats caused by one accepted input
    function void note_input(logic [1:0] op, logic [7:0] id, logic [15:0] p,
                             logic [7:0] pr, logic [15:0] r);
        int n;
        logic [7:0]  t8;
        logic [15:0] t16;
        n = 0;
        case (op)
            tts_pkg::OP_TICK:
            begin
                for (int i = 0; i < count; i++)
                begin
                    rem[i] = rem[i] - 16'd1;
                    if (rem[i] == 16'd0)
                    begin
                        rem[i] = per[i];
                        if (n < 8)
                        begin
                            push(1'b1, tid[i], i[2:0], 1'b0, 1'b0);
                            n++;
                        end
                    end
                end
                if (n == 0)
                    push(1'b0, 8'd0, 3'd0, 1'b0, 1'b1);
                else
                    pending[pending.size()-1].last = 1'b1;
            end
            tts_pkg::OP_ADD:
            begin
                if (count < 8)
                begin
                    tid[count] = id; per[count] = p; pri[count] = pr; rem[count] = r;
                    count++;
                    push(1'b0, 8'd0, 3'd0, 1'b1, 1'b1);
                end
                else
                    push(1'b0, 8'd0, 3'd0, 1'b0, 1'b1);
            end
            tts_pkg::OP_SORT:
            begin
                for (int i = 0; i + 1 < count; i++)
                    for (int j = i + 1; j < count; j++)
                        if (pri[i] > pri[j])
                        begin
                            t8 = tid[i]; tid[i] = tid[j]; tid[j] = t8;
                            t8 = pri[i]; pri[i] = pri[j]; pri[j] = t8;
                            t16 = per[i]; per[i] = per[j]; per[j] = t16;
                            t16 = rem[i]; rem[i] = rem[j]; rem[j] = t16;
                        end
                push(1'b0, 8'd0, 3'd0, 1'b0, 1'b1);
            end
            default:
            begin
                if (count == 0)
                    push(1'b0, 8'd0, 3'd0, 1'b0, 1'b1);
                else
                begin
                    for (int i = 0; i + 1 < count; i++)
                    begin
                        tid[i] = tid[i+1]; per[i] = per[i+1];
                        pri[i] = pri[i+1]; rem[i] = rem[i+1];
                    end
                    count--;
                    push(1'b0, 8'd0, 3'd0, 1'b1, 1'b1);
                end
            end
        endcase
    endfunction

    function void report(string what, int got, int want);
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
        errors++;
    endfunction

    function void check_beat(logic f, logic [7:0] id, logic [2:0] s, logic a,
                             logic [3:0] c, logic l);
        beat_t b;
        if (pending.size() == 0)
        begin
            report("unexpected result beat", 1, 0);
            return;
        end
        b = pending.pop_front();
        if (f !== b.fired) report("fired", f, b.fired);
        if (id !== b.id) report("fired_task_id", id, b.id);
        if (s !== b.slot) report("fired_slot", s, b.slot);
        if (a !== b.acc) report("accepted", a, b.acc);
        if (c !== b.cnt) report("task_count", c, b.cnt);
        if (l !== b.last) report("last", l, b.last);
    endfunction
endclass

module testbench;
    import tts_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_TICK;
    logic [7:0]  new_task_id = '0;
    logic [15:0] new_period = '0;
    logic [7:0]  new_priority = '0;
    logic [15:0] new_initial_remain = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        fired;
    logic [7:0]  fired_task_id;
    logic [2:0]  fired_slot;
    logic        accepted;
    logic [3:0]  task_count;
    logic        last;

    sched_scoreboard sb = new();
    bit quiet = 1'b0;        // no idling once set
    int idle_cycles = 0;     // watchdog counter
    localparam int WATCHDOG = 20000;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tick_task_scheduler u_top (.*);

    // result side: random stall bursts, check each accepted beat
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_beat(fired, fired_task_id, fired_slot, accepted, task_count, last);
            if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // present one input beat, hold until accepted, then note it
    task automatic send_op(logic [1:0] op, logic [7:0] id, logic [15:0] p,
                           logic [7:0] pr, logic [15:0] r);
        in_valid <= 1'b1;
        operation <= op;
        new_task_id <= id;
        new_period <= p;
        new_priority <= pr;
        new_initial_remain <= r;
        do @(posedge clk); while (in_stall);
        sb.note_input(op, id, p, pr, r);
        // sender idle burst
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_add(logic [7:0] id, logic [15:0] p, logic [7:0] pr, logic [15:0] r);
        send_op(OP_ADD, id, p, pr, r);
    endtask

    task automatic send_rand_op(logic [1:0] op);
        send_op(op, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        int r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty remove, empty tick, empty sort
        send_rand_op(OP_REMOVE);
        send_rand_op(OP_TICK);
        send_rand_op(OP_SORT);
        // extremes of the fields; period zero task and remaining of one
        send_add(8'hFF, 16'hFFFF, 8'hFF, 16'd1);
        send_add(8'h00, 16'd0, 8'h00, 16'd0);
        send_add(8'hA5, 16'd1, 8'h80, 16'd1);
        send_add(8'h5A, 16'd2, 8'h7F, 16'hFFFF);
        send_add(8'h11, 16'd1, 8'h80, 16'd1);
        send_add(8'h22, 16'd1, 8'h01, 16'd1);
        send_add(8'h33, 16'd1, 8'h01, 16'd1);
        send_add(8'h44, 16'd1, 8'hFE, 16'd1);
        // full table: rejected
        send_add(8'h55, 16'd3, 8'h03, 16'd3);
        send_rand_op(OP_TICK);
        send_rand_op(OP_TICK);
        send_rand_op(OP_SORT);
        send_rand_op(OP_TICK);
        send_rand_op(OP_REMOVE);
        send_rand_op(OP_SORT);
        // sender holds off until everything has come back
        wait_drain();
        repeat (7) send_rand_op(OP_REMOVE);
        send_rand_op(OP_SORT);
        send_rand_op(OP_REMOVE);
        send_rand_op(OP_REMOVE);

        // random part: mostly adds of short periods and ticks so tasks fire
        for (int k = 0; k < 172; k++)
        begin
            if (k == 140)
                quiet = 1'b1;
            r = $urandom_range(0, 9);
            if (r < 4)
                send_rand_op(OP_TICK);
            else if (r < 7)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_rand_op(OP_ADD);
                else
                    send_add(8'($urandom), 16'($urandom_range(0, 6)), 8'($urandom),
                             16'($urandom_range(0, 6)));
            end
            else if (r < 8)
                send_rand_op(OP_SORT);
            else
                send_rand_op(OP_REMOVE);
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/tts_pkg.sv
rtl/tts_ram.sv
rtl/tick_task_scheduler.sv
tb/testbench.sv
